[hdl/tksit_pkg.sv]
// tksit_pkg: shared types and constants of the top-k sorted insert table
// used by the controller, the datapath and the top level; no dependencies
`default_nettype none

package tksit_pkg;

  // table geometry
  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);

  // field widths
  localparam int SCORE_W = 32;
  localparam int TAG_W   = 64;
  localparam int RIDX_W  = 4;
  localparam int POS_W   = 4;

  // score value that marks an empty slot
  localparam logic signed [SCORE_W-1:0] EMPTY_SCORE = -32'sd1;

  // command codes
  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_READ   = 1'b1
  } cmd_t;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_in;
    logic exec;
  } tksit_ctrl_t;

endpackage

`default_nettype wire

[hdl/tksit_ctrl.sv]
// tksit_ctrl: controller state machine of the top-k sorted insert table
// depends on tksit_pkg; drives the datapath commands and the handshakes
`default_nettype none

module tksit_ctrl
  import tksit_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  wire logic  out_stall,
  output tksit_ctrl_t ctrl
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // the output register can take a new result this cycle
  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath commands
  always_comb begin
    in_stall     = 1'b1;
    ctrl.load_in = 1'b0;
    ctrl.exec    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall     = 1'b0;
        ctrl.load_in = in_valid;
      end
      ST_EXEC: begin
        ctrl.exec = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.exec) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTH
  // a captured item always moves on to the execute step
  a_load_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.load_in |=> (state_r == ST_EXEC))
    else $error("captured item did not reach execute");

  // an executed item always shows up as a valid result
  a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.exec |=> out_valid_r)
    else $error("executed item produced no result");

  // execution waits while the previous result is still stalled
  a_exec_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && out_valid_r && out_stall) |-> !ctrl.exec)
    else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire

[hdl/tksit_dp.sv]
// tksit_dp: datapath of the top-k sorted insert table (input capture,
// score and tag slots, parallel compare and shift, result register); uses tksit_pkg
`default_nettype none

module tksit_dp
  import tksit_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire tksit_ctrl_t               ctrl,
  input  wire logic                      in_command,
  input  wire logic signed [SCORE_W-1:0] in_score,
  input  wire logic        [TAG_W-1:0]   in_name_tag,
  input  wire logic        [RIDX_W-1:0]  in_read_index,
  output logic                           out_accepted,
  output logic             [POS_W-1:0]   out_position,
  output logic signed      [SCORE_W-1:0] out_lowest_score,
  output logic signed      [SCORE_W-1:0] out_read_score,
  output logic             [TAG_W-1:0]   out_read_tag
);

  // captured input item
  cmd_t                      cmd_r;
  logic signed [SCORE_W-1:0] score_r;
  logic        [TAG_W-1:0]   tag_r;
  logic        [RIDX_W-1:0]  ridx_r;

  // table slots
  logic signed [SCORE_W-1:0] score_tab_r   [ENTRIES];
  logic signed [SCORE_W-1:0] score_tab_nxt [ENTRIES];
  logic        [TAG_W-1:0]   tag_tab_r     [ENTRIES];
  logic        [TAG_W-1:0]   tag_tab_nxt   [ENTRIES];

  // result register
  logic                      accepted_r;
  logic        [POS_W-1:0]   position_r;
  logic signed [SCORE_W-1:0] lowest_r;
  logic signed [SCORE_W-1:0] rscore_r, rscore_nxt;
  logic        [TAG_W-1:0]   rtag_r, rtag_nxt;

  logic signed [SCORE_W-1:0] last_score;
  logic        [IDX_W-1:0]   ins_pos;
  logic                      reject;
  logic                      do_insert;

  // input capture
  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      cmd_r   <= cmd_t'(in_command);
      score_r <= in_score;
      tag_r   <= in_name_tag;
      ridx_r  <= in_read_index;
    end
  end

  // insert decision and landing slot: just below the last slot that holds
  // a score equal or higher, among all slots but the last
  assign last_score = score_tab_r[ENTRIES-1];
  assign reject     = (score_r == EMPTY_SCORE) ||
                      ((last_score != EMPTY_SCORE) && (score_r <= last_score));
  assign do_insert  = ctrl.exec && (cmd_r == CMD_INSERT) && !reject;

  always_comb begin
    ins_pos = '0;
    for (int j = 0; j < ENTRIES - 1; j++) begin
      if (score_tab_r[j] >= score_r) ins_pos = IDX_W'(j + 1);
    end
  end

  // one-step shift below the landing slot
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      score_tab_nxt[i] = score_tab_r[i];
      tag_tab_nxt[i]   = tag_tab_r[i];
    end
    if (do_insert) begin
      for (int i = 1; i < ENTRIES; i++) begin
        if (i > int'(ins_pos)) begin
          score_tab_nxt[i] = score_tab_r[i-1];
          tag_tab_nxt[i]   = tag_tab_r[i-1];
        end
      end
      for (int i = 0; i < ENTRIES; i++) begin
        if (i == int'(ins_pos)) begin
          score_tab_nxt[i] = score_r;
          tag_tab_nxt[i]   = tag_r;
        end
      end
    end
  end

  // read select; a slot past the table reads as empty
  always_comb begin
    rscore_nxt = '0;
    rtag_nxt   = '0;
    if (cmd_r == CMD_READ) begin
      rscore_nxt = EMPTY_SCORE;
      for (int j = 0; j < ENTRIES; j++) begin
        if (int'(ridx_r) == j) begin
          rscore_nxt = score_tab_r[j];
          rtag_nxt   = tag_tab_r[j];
        end
      end
    end
  end

  // table slots
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        score_tab_r[i] <= EMPTY_SCORE;
        tag_tab_r[i]   <= '0;
      end
    end else begin
      for (int i = 0; i < ENTRIES; i++) begin
        score_tab_r[i] <= score_tab_nxt[i];
        tag_tab_r[i]   <= tag_tab_nxt[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      accepted_r <= do_insert;
      position_r <= do_insert ? POS_W'(ins_pos) : '0;
      lowest_r   <= score_tab_nxt[ENTRIES-1];
      rscore_r   <= rscore_nxt;
      rtag_r     <= rtag_nxt;
    end
  end

  assign out_accepted     = accepted_r;
  assign out_position     = position_r;
  assign out_lowest_score = lowest_r;
  assign out_read_score   = rscore_r;
  assign out_read_tag     = rtag_r;

endmodule

`default_nettype wire

[hdl/top_k_sorted_insert_table.sv]
// top_k_sorted_insert_table: top level of the top-k sorted insert table
// instantiates tksit_ctrl and tksit_dp; uses tksit_pkg
//
// Keeps the sixteen highest scores with their 64-bit tags in descending order
// and answers insert and read commands with one result each. An item is first
// captured, then in the execute step every slot is compared against the new
// score in parallel and the table shifts by one step. The result then sits in
// an output register, and the next item is taken at once even while that
// result waits; only that item's execute step holds off until the output
// register is free. No item is taken while another waits for its execute step.
// After reset all slots are empty (score -1, tag 0).
`default_nettype none

module top_k_sorted_insert_table
  import tksit_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      in_command,
  input  wire logic signed [SCORE_W-1:0] in_score,
  input  wire logic        [TAG_W-1:0]   in_name_tag,
  input  wire logic        [RIDX_W-1:0]  in_read_index,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           out_accepted,
  output logic             [POS_W-1:0]   out_position,
  output logic signed      [SCORE_W-1:0] out_lowest_score,
  output logic signed      [SCORE_W-1:0] out_read_score,
  output logic             [TAG_W-1:0]   out_read_tag
);

  tksit_ctrl_t ctrl;

  // control
  tksit_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctrl      (ctrl)
  );

  // table and result datapath
  tksit_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl             (ctrl),
    .in_command       (in_command),
    .in_score         (in_score),
    .in_name_tag      (in_name_tag),
    .in_read_index    (in_read_index),
    .out_accepted     (out_accepted),
    .out_position     (out_position),
    .out_lowest_score (out_lowest_score),
    .out_read_score   (out_read_score),
    .out_read_tag     (out_read_tag)
  );

endmodule

`default_nettype wire
